// ===== sv/arp_cache_responder_unit_defines.svh =====
// Assertion macros for the checker file of the ARP cache responder.
// No dependencies; include by bare file name.
`ifndef ARP_CACHE_RESPONDER_UNIT_DEFINES_SVH
`define ARP_CACHE_RESPONDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/acr_pkg.sv =====
// Types, codes and constants of the ARP cache responder.
// No dependencies; used by every RTL and checker file of the block.
`default_nettype none

package acr_pkg;

  localparam int unsigned CACHE_ENTRIES_DEF = 16;

  localparam int unsigned MAC_W = 48;
  localparam int unsigned IP_W  = 32;
  localparam int unsigned OP_W  = 16;

  localparam logic [OP_W-1:0]  ARP_OP_REQUEST = 16'd1;
  localparam logic [OP_W-1:0]  ARP_OP_REPLY   = 16'd2;
  localparam logic [7:0]       ARP_HW_LEN     = 8'h06;
  localparam logic [7:0]       ARP_PROTO_LEN  = 8'h04;
  localparam logic [MAC_W-1:0] BCAST_MAC      = {MAC_W{1'b1}};

  localparam logic [15:0] LINK_TYPE_RST = 16'h0001;
  localparam logic [15:0] NET_TYPE_RST  = 16'h0800;

  typedef enum logic {
    FUNC_RESOLVE = 1'b0,
    FUNC_PACKET  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    REG_OWN_MAC   = 2'd0,
    REG_OWN_IP    = 2'd1,
    REG_LINK_TYPE = 2'd2,
    REG_NET_TYPE  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_HIT     = 2'd1,
    KIND_REQUEST = 2'd2,
    KIND_REPLY   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

  typedef struct packed {
    kind_e            kind;
    logic [MAC_W-1:0] found_mac;
    logic [OP_W-1:0]  opcode;
    logic [MAC_W-1:0] dest_mac;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  sender_ip;
    logic [MAC_W-1:0] target_mac;
    logic [IP_W-1:0]  target_ip;
  } result_t;

  // Compare outcome of the cache for the entry read in the previous cycle.
  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac;
  } cmp_t;

endpackage

`default_nettype wire

// ===== sv/arp_cache_responder_unit.sv =====
// ARP cache and responder: one received request at a time runs a linear scan of the
// cache through one compare unit, then issues one result; a packet with a bad header
// skips the scan. A scan ends early on a hit, else after the last cache entry. The
// scan reads one cache entry per cycle through the single memory read port and
// compares it against the key, so the cache depth sets the time. Valid bits clear at
// reset; no clearing pass is needed. A finished result sits in an output register,
// so the next request may be taken while it waits.
// Depends on acr_pkg and acr_cache.
`default_nettype none

module arp_cache_responder_unit
  import acr_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [MAC_W-1:0] cfg_data_i,
  // request channel
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             func_i,
  input  wire logic [IP_W-1:0]  query_ip_i,
  input  wire logic [OP_W-1:0]  rx_opcode_i,
  input  wire logic [15:0]      rx_hw_type_i,
  input  wire logic [15:0]      rx_proto_type_i,
  input  wire logic [7:0]       rx_hw_len_i,
  input  wire logic [7:0]       rx_proto_len_i,
  input  wire logic [MAC_W-1:0] rx_sender_mac_i,
  input  wire logic [IP_W-1:0]  rx_sender_ip_i,
  input  wire logic [MAC_W-1:0] rx_target_mac_i,
  input  wire logic [IP_W-1:0]  rx_target_ip_i,
  // result channel
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            result_kind_o,
  output logic [MAC_W-1:0]      found_mac_o,
  output logic [OP_W-1:0]       tx_opcode_o,
  output logic [MAC_W-1:0]      tx_dest_mac_o,
  output logic [MAC_W-1:0]      tx_sender_mac_o,
  output logic [IP_W-1:0]       tx_sender_ip_o,
  output logic [MAC_W-1:0]      tx_target_mac_o,
  output logic [IP_W-1:0]       tx_target_ip_o
);

  localparam int unsigned IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CACHE_ENTRIES - 1);

  // configuration registers
  logic [MAC_W-1:0] own_mac_q;
  logic [IP_W-1:0]  own_ip_q;
  logic [15:0]      link_type_q;
  logic [15:0]      net_type_q;

  // sequencer
  state_e state_q, state_d;
  logic   accept;
  logic   rd_en;
  logic   finish;
  logic   hdr_ok_in;

  // captured request
  logic             func_q;
  logic [IP_W-1:0]  key_q;
  logic             op_req_q;
  logic [MAC_W-1:0] smac_q;
  logic [IP_W-1:0]  tip_q;
  logic             hdr_ok_q;
  logic             tgt_ok_q;

  // scan
  logic [IdxW-1:0]  scan_q;
  logic [IdxW-1:0]  chk_idx_q;
  logic             rdv_q;
  logic             hit_q;
  logic [IdxW-1:0]  hit_idx_q;
  logic [MAC_W-1:0] hit_mac_q;
  logic [IdxW-1:0]  next_slot_q;
  cmp_t             cmp;

  // update and result
  logic             wr_en;
  logic [IdxW-1:0]  wr_idx;
  logic             new_slot;
  entry_t           wr_entry;
  result_t          res_d;
  result_t          out_q;
  logic             out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q   <= '0;
      own_ip_q    <= '0;
      link_type_q <= LINK_TYPE_RST;
      net_type_q  <= NET_TYPE_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_OWN_MAC:   own_mac_q   <= cfg_data_i;
        REG_OWN_IP:    own_ip_q    <= cfg_data_i[IP_W-1:0];
        REG_LINK_TYPE: link_type_q <= cfg_data_i[15:0];
        REG_NET_TYPE:  net_type_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign hdr_ok_in = (rx_hw_type_i == link_type_q) && (rx_proto_type_i == net_type_q) &&
                     (rx_hw_len_i == ARP_HW_LEN) && (rx_proto_len_i == ARP_PROTO_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    finish     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          // skip the scan for a packet with a bad header
          if (func_i == FUNC_RESOLVE || hdr_ok_in) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (rdv_q && (cmp.hit || chk_idx_q == LastIdx)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= func_i;
      key_q     <= (func_i == FUNC_RESOLVE) ? query_ip_i : rx_sender_ip_i;
      op_req_q  <= (rx_opcode_i == ARP_OP_REQUEST);
      smac_q    <= rx_sender_mac_i;
      tip_q     <= rx_target_ip_i;
      hdr_ok_q  <= hdr_ok_in;
      tgt_ok_q  <= (rx_target_ip_i == own_ip_q);
      scan_q    <= '0;
      hit_q     <= 1'b0;
    end else if (state_q == ST_SCAN) begin
      chk_idx_q <= scan_q;
      if (scan_q != LastIdx) begin
        scan_q <= scan_q + 1'b1;
      end
      if (state_d == ST_FINISH) begin
        hit_q     <= cmp.hit;
        hit_idx_q <= chk_idx_q;
        hit_mac_q <= cmp.mac;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q <= 1'b0;
    end else begin
      rdv_q <= (state_q == ST_SCAN) && (state_d == ST_SCAN);
    end
  end

  // at most one write per packet: refresh a hit in place, or fill the round-robin slot
  assign new_slot = (func_q == FUNC_PACKET) && hdr_ok_q && tgt_ok_q && !hit_q;
  assign wr_en    = finish && (func_q == FUNC_PACKET) && hdr_ok_q && (hit_q || tgt_ok_q);
  assign wr_idx   = hit_q ? hit_idx_q : next_slot_q;
  assign wr_entry = '{ip: key_q, mac: smac_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_slot_q <= '0;
    end else if (finish && new_slot) begin
      next_slot_q <= (next_slot_q == LastIdx) ? '0 : next_slot_q + 1'b1;
    end
  end

  acr_cache #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_cache (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_idx_i  (scan_q),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_entry_i(wr_entry),
    .key_i     (key_q),
    .cmp_o     (cmp)
  );

  always_comb begin
    res_d = '0;
    res_d.kind = KIND_NONE;
    if (func_q == FUNC_RESOLVE) begin
      if (hit_q) begin
        res_d.kind      = KIND_HIT;
        res_d.found_mac = hit_mac_q;
      end else begin
        res_d.kind       = KIND_REQUEST;
        res_d.opcode     = ARP_OP_REQUEST;
        res_d.dest_mac   = BCAST_MAC;
        res_d.sender_mac = own_mac_q;
        res_d.sender_ip  = own_ip_q;
        res_d.target_ip  = key_q;
      end
    end else if (hdr_ok_q && tgt_ok_q && op_req_q) begin
      res_d.kind       = KIND_REPLY;
      res_d.opcode     = ARP_OP_REPLY;
      res_d.dest_mac   = smac_q;
      res_d.sender_mac = own_mac_q;
      res_d.sender_ip  = tip_q;
      res_d.target_mac = smac_q;
      res_d.target_ip  = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_q.kind;
  assign found_mac_o     = out_q.found_mac;
  assign tx_opcode_o     = out_q.opcode;
  assign tx_dest_mac_o   = out_q.dest_mac;
  assign tx_sender_mac_o = out_q.sender_mac;
  assign tx_sender_ip_o  = out_q.sender_ip;
  assign tx_target_mac_o = out_q.target_mac;
  assign tx_target_ip_o  = out_q.target_ip;

endmodule

`default_nettype wire

// ===== sv/acr_cache.sv =====
// Cache storage (address/MAC memory plus valid flops) and the shared IP compare unit.
// Depends on acr_pkg.
`default_nettype none

module acr_cache
  import acr_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF,
  localparam int unsigned IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rd_en_i,
  input  wire logic [IdxW-1:0] rd_idx_i,
  input  wire logic            wr_en_i,
  input  wire logic [IdxW-1:0] wr_idx_i,
  input  wire entry_t          wr_entry_i,
  input  wire logic [IP_W-1:0] key_i,
  output cmp_t                 cmp_o
);

  entry_t                   mem [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] valid_q;
  entry_t                   rd_q;
  logic                     rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign cmp_o.hit = rd_vld_q && (rd_q.ip == key_i);
  assign cmp_o.mac = rd_q.mac;

endmodule

`default_nettype wire

// ===== sv/acr_checker.sv =====
// Port-level checker for the ARP cache responder, bound to the top level.
// Depends on acr_pkg and arp_cache_responder_unit_defines.svh.
`default_nettype none

`include "arp_cache_responder_unit_defines.svh"

module acr_checker
  import acr_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [1:0]       result_kind_o,
  input wire logic [MAC_W-1:0] found_mac_o,
  input wire logic [OP_W-1:0]  tx_opcode_o,
  input wire logic [MAC_W-1:0] tx_dest_mac_o,
  input wire logic [MAC_W-1:0] tx_target_mac_o
);

  // a stalled result must hold
  `ACR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(result_kind_o) && $stable(found_mac_o) && $stable(tx_dest_mac_o), "result changed while stalled")

  // a taken request keeps the sequencer busy, so ready drops once it is taken
  `ACR_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready high right after a request was taken")

  `ACR_ASSERT_IMP(a_hit_no_tx, clk_i, rst_ni, out_valid_o && (result_kind_o == KIND_HIT), (tx_opcode_o == '0) && (tx_dest_mac_o == '0), "resolve hit carries packet fields")

  `ACR_ASSERT_IMP(a_req_shape, clk_i, rst_ni, out_valid_o && (result_kind_o == KIND_REQUEST), (tx_opcode_o == ARP_OP_REQUEST) && (tx_dest_mac_o == BCAST_MAC) && (tx_target_mac_o == '0) && (found_mac_o == '0), "malformed ARP request")

  `ACR_ASSERT_IMP(a_reply_shape, clk_i, rst_ni, out_valid_o && (result_kind_o == KIND_REPLY), (tx_opcode_o == ARP_OP_REPLY) && (tx_dest_mac_o == tx_target_mac_o) && (found_mac_o == '0), "malformed ARP reply")

endmodule

bind arp_cache_responder_unit acr_checker u_acr_checker (.*);

`default_nettype wire
